/* rtl/core/ddcm_pkg.sv */
// Package for the dual deque card mover: item structs, action codes,
// command bit positions and register map. No dependencies.
package ddcm_pkg;

  localparam int CARD_W   = 7;
  localparam int SIZE_W   = 7;
  localparam int CNT_CFG_W = 6;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 3;

  localparam logic [CNT_CFG_W-1:0] CARD_COUNT_RST = 6'd8;

  // Register index of card_count, as decoded from paddr[2].
  localparam logic REG_CARD_COUNT = 1'b0;

  // Bit positions in the move command.
  localparam int CMD_SRC_RIGHT = 3;
  localparam int CMD_FROM_BOT  = 2;
  localparam int CMD_DST_RIGHT = 1;
  localparam int CMD_TO_BOT    = 0;

  typedef enum logic [1:0] {
    ACT_LOAD      = 2'd0,
    ACT_MOVE      = 2'd1,
    ACT_POP_LEFT  = 2'd2,
    ACT_POP_RIGHT = 2'd3
  } action_t;

  typedef struct packed {
    action_t    action;
    logic [3:0] command;
  } in_item_t;

  typedef struct packed {
    logic signed [CARD_W-1:0] card_value;
    logic                     card_valid;
    logic [SIZE_W-1:0]        left_size;
    logic [SIZE_W-1:0]        right_size;
  } out_item_t;

endpackage

/* rtl/core/dual_deque_card_mover.sv */
// Dual deque card mover: two ring-buffer deques held in two RAMs.
// A move or pop is accepted in the idle cycle, which also issues the RAM read;
// the next cycle (S_XFER) writes back and registers the result once the output
// register is free. A new item is taken only in S_IDLE, after the result is registered.
// A load writes n RAM entries in both RAMs, then registers the result once the output is free.
// Synchronous active-low reset empties both deques and sets card_count to 8.
module dual_deque_card_mover #(
  parameter int MAX_CARDS  = 32,
  parameter int RING_DEPTH = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  ddcm_pkg::in_item_t           in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output ddcm_pkg::out_item_t          out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ddcm_pkg::ADDR_W-1:0]  paddr,
  input  logic [ddcm_pkg::DATA_W-1:0]  pwdata,
  output logic [ddcm_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);

  import ddcm_pkg::*;

  localparam int PW       = $clog2(RING_DEPTH);
  localparam int CW       = $clog2(RING_DEPTH + 1);
  localparam int LOAD_MAX = (MAX_CARDS < RING_DEPTH) ? MAX_CARDS : RING_DEPTH;
  localparam logic [CW-1:0] FULL     = CW'(RING_DEPTH);
  localparam logic [PW-1:0] LAST_IDX = PW'(RING_DEPTH - 1);

  typedef struct packed {
    logic [PW-1:0] head;
    logic [PW-1:0] tail;
    logic [CW-1:0] count;
  } ptr_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_XFER = 3'b010,
    S_LOAD = 3'b100
  } state_t;

  function automatic logic [PW-1:0] ring_prev(input logic [PW-1:0] i);
    return (i == '0) ? LAST_IDX : PW'(i - 1'b1);
  endfunction

  function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] i);
    return (i == LAST_IDX) ? '0 : PW'(i + 1'b1);
  endfunction

  function automatic ptr_t pop_ptr(input ptr_t p, input logic bottom);
    ptr_t q;
    q = p;
    if (bottom) begin
      q.tail = ring_prev(p.tail);
    end else begin
      q.head = ring_next(p.head);
    end
    q.count = CW'(p.count - 1'b1);
    return q;
  endfunction

  function automatic ptr_t push_ptr(input ptr_t p, input logic bottom);
    ptr_t q;
    q = p;
    if (bottom) begin
      q.tail = ring_next(p.tail);
    end else begin
      q.head = ring_prev(p.head);
    end
    q.count = CW'(p.count + 1'b1);
    return q;
  endfunction

  function automatic logic [PW-1:0] push_addr(input ptr_t p, input logic bottom);
    return bottom ? p.tail : ring_prev(p.head);
  endfunction

  state_t                state_r, state_nxt;
  ptr_t                  left_r, left_nxt;
  ptr_t                  right_r, right_nxt;
  action_t               act_r, act_nxt;
  logic [3:0]            cmd_r, cmd_nxt;
  logic                  ok_r, ok_nxt;
  logic [CW-1:0]         n_r, n_nxt;
  logic [CW-1:0]         idx_r, idx_nxt;
  logic [CNT_CFG_W-1:0]  card_count_r, card_count_nxt;
  out_item_t             out_r, out_nxt;
  logic                  out_valid_r, out_valid_nxt;

  logic                  accept;
  logic                  out_free;
  logic                  take_bottom;
  logic                  src_right_in;
  logic                  src_right;
  logic [CW-1:0]         src_cnt;
  logic [CW-1:0]         dst_cnt;
  logic [CARD_W:0]       cfg_n;
  logic [CARD_W-1:0]     card;
  logic [CARD_W-1:0]     load_val;

  logic                  l_wr_en, r_wr_en, rd_en;
  logic [PW-1:0]         l_wr_addr, r_wr_addr, l_rd_addr, r_rd_addr;
  logic [CARD_W-1:0]     l_wr_data, r_wr_data, l_rd_data, r_rd_data;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == REG_CARD_COUNT) ? DATA_W'(card_count_r) : '0;

  // The RAM read is issued in the acceptance cycle from the incoming command.
  assign take_bottom  = (in_data.action == ACT_MOVE) && in_data.command[CMD_FROM_BOT];
  assign src_right_in = (in_data.action == ACT_MOVE) ? in_data.command[CMD_SRC_RIGHT]
                                                     : (in_data.action == ACT_POP_RIGHT);
  assign rd_en     = accept;
  assign l_rd_addr = take_bottom ? ring_prev(left_r.tail) : left_r.head;
  assign r_rd_addr = take_bottom ? ring_prev(right_r.tail) : right_r.head;

  assign src_cnt  = src_right_in ? right_r.count : left_r.count;
  assign dst_cnt  = in_data.command[CMD_DST_RIGHT] ? right_r.count : left_r.count;
  assign cfg_n    = (CARD_W + 1)'(card_count_r);
  assign src_right = (act_r == ACT_MOVE) ? cmd_r[CMD_SRC_RIGHT] : (act_r == ACT_POP_RIGHT);
  assign card      = src_right ? r_rd_data : l_rd_data;
  assign load_val  = CARD_W'(idx_r) + CARD_W'(1);

  always_comb begin
    ptr_t lp;
    ptr_t rp;
    lp             = left_r;
    rp             = right_r;
    state_nxt      = state_r;
    left_nxt       = left_r;
    right_nxt      = right_r;
    act_nxt        = act_r;
    cmd_nxt        = cmd_r;
    ok_nxt         = ok_r;
    n_nxt          = n_r;
    idx_nxt        = idx_r;
    card_count_nxt = card_count_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    l_wr_en        = 1'b0;
    r_wr_en        = 1'b0;
    l_wr_addr      = idx_r[PW-1:0];
    r_wr_addr      = idx_r[PW-1:0];
    l_wr_data      = load_val;
    r_wr_data      = CARD_W'(0) - load_val;

    if (psel && penable && pwrite && pready && (paddr[2] == REG_CARD_COUNT)) begin
      card_count_nxt = pwdata[CNT_CFG_W-1:0];
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          act_nxt = in_data.action;
          cmd_nxt = in_data.command;
          idx_nxt = '0;
          n_nxt   = (cfg_n > (CARD_W + 1)'(LOAD_MAX)) ? CW'(LOAD_MAX) : CW'(cfg_n);
          if (in_data.action == ACT_MOVE) begin
            ok_nxt = (src_cnt != '0) &&
                     ((in_data.command[CMD_SRC_RIGHT] == in_data.command[CMD_DST_RIGHT]) ||
                      (dst_cnt != FULL));
          end else begin
            ok_nxt = (src_cnt != '0);
          end
          state_nxt = (in_data.action == ACT_LOAD) ? S_LOAD : S_XFER;
        end
      end
      S_XFER: begin
        if (out_free) begin
          if (ok_r) begin
            if (src_right) begin
              rp = pop_ptr(rp, (act_r == ACT_MOVE) && cmd_r[CMD_FROM_BOT]);
            end else begin
              lp = pop_ptr(lp, (act_r == ACT_MOVE) && cmd_r[CMD_FROM_BOT]);
            end
            // The push sees the pointers after the pop, so a move within one
            // deque behaves as the two steps one after the other.
            if (act_r == ACT_MOVE) begin
              if (cmd_r[CMD_DST_RIGHT]) begin
                r_wr_en   = 1'b1;
                r_wr_addr = push_addr(rp, cmd_r[CMD_TO_BOT]);
                r_wr_data = card;
                rp        = push_ptr(rp, cmd_r[CMD_TO_BOT]);
              end else begin
                l_wr_en   = 1'b1;
                l_wr_addr = push_addr(lp, cmd_r[CMD_TO_BOT]);
                l_wr_data = card;
                lp        = push_ptr(lp, cmd_r[CMD_TO_BOT]);
              end
            end
          end
          left_nxt           = lp;
          right_nxt          = rp;
          out_nxt.card_value = ok_r ? card : '0;
          out_nxt.card_valid = ok_r;
          out_nxt.left_size  = SIZE_W'(lp.count);
          out_nxt.right_size = SIZE_W'(rp.count);
          out_valid_nxt      = 1'b1;
          state_nxt          = S_IDLE;
        end
      end
      S_LOAD: begin
        if (idx_r != n_r) begin
          l_wr_en = 1'b1;
          r_wr_en = 1'b1;
          idx_nxt = CW'(idx_r + 1'b1);
        end else if (out_free) begin
          lp.head  = '0;
          lp.tail  = (n_r == FULL) ? '0 : n_r[PW-1:0];
          lp.count = n_r;
          left_nxt           = lp;
          right_nxt          = lp;
          out_nxt.card_value = '0;
          out_nxt.card_valid = 1'b0;
          out_nxt.left_size  = SIZE_W'(n_r);
          out_nxt.right_size = SIZE_W'(n_r);
          out_valid_nxt      = 1'b1;
          state_nxt          = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      left_r       <= '0;
      right_r      <= '0;
      card_count_r <= CARD_COUNT_RST;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      left_r       <= left_nxt;
      right_r      <= right_nxt;
      card_count_r <= card_count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r <= act_nxt;
    cmd_r <= cmd_nxt;
    ok_r  <= ok_nxt;
    n_r   <= n_nxt;
    idx_r <= idx_nxt;
    out_r <= out_nxt;
  end

  ddcm_ram #(
    .WIDTH (CARD_W),
    .DEPTH (RING_DEPTH)
  ) u_left_ram (
    .clk     (clk),
    .wr_en   (l_wr_en),
    .wr_addr (l_wr_addr),
    .wr_data (l_wr_data),
    .rd_en   (rd_en),
    .rd_addr (l_rd_addr),
    .rd_data (l_rd_data)
  );

  ddcm_ram #(
    .WIDTH (CARD_W),
    .DEPTH (RING_DEPTH)
  ) u_right_ram (
    .clk     (clk),
    .wr_en   (r_wr_en),
    .wr_addr (r_wr_addr),
    .wr_data (r_wr_data),
    .rd_en   (rd_en),
    .rd_addr (r_rd_addr),
    .rd_data (r_rd_data)
  );

  // Moves and pops never add cards, so the total never exceeds what a load puts in both deques.
  a_card_total: assert property (@(posedge clk) disable iff (!rst_n)
    ((CW + 1)'(left_r.count) + (CW + 1)'(right_r.count)) <= (CW + 1)'(2 * LOAD_MAX))
    else $error("deques hold more cards than a load can provide");

  // No card carries the value zero, so a reported card is never zero.
  a_valid_card: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.card_valid) |-> (out_data.card_value != '0))
    else $error("valid result carries a zero card");

  // A move or pop goes straight to the write-back cycle after acceptance.
  a_xfer_next: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_data.action != ACT_LOAD)) |=> (state_r == S_XFER))
    else $error("move or pop did not enter write-back");

endmodule

/* rtl/core/ddcm_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with a
// registered read and read enable. No dependencies.
module ddcm_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
